/* hdl/ccp_pkg.sv */
`default_nettype none

package ccp_pkg;

	localparam int COEFFS_PER_POLY_DEF = 256;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam logic signed [12:0] COEF_MIN = -13'sd3329;
	localparam logic signed [12:0] COEF_MAX = 13'sd3328;
	localparam logic signed [13:0] Q_MOD    = 14'sd3329;

	localparam logic [16:0] HALF_Q    = 17'd1664;
	localparam logic [25:0] MUL_CONST = 26'd315;
	localparam int          MUL_SHIFT = 20;

	localparam logic [2:0] MODE_D5 = 3'd5;
	localparam logic [2:0] MODE_RESET = 3'd4;

	localparam logic [3:0] BYTE_BITS = 4'd8;

	// one compressed coefficient on its way from the front end to the packer
	typedef struct packed {
		logic [4:0] code;
		logic       d5;
		logic       last;
	} entry_t;

endpackage

`default_nettype wire

/* hdl/ccp_front.sv */
`default_nettype none

module ccp_front import ccp_pkg::*; #(
	parameter int COEFFS_PER_POLY = COEFFS_PER_POLY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [12:0] coefficient,
	input  wire logic               d5,
	output logic                    q_push,
	output entry_t                  q_entry,
	input  wire logic               q_full
);

	localparam int PW = (COEFFS_PER_POLY > 1) ? $clog2(COEFFS_PER_POLY) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(COEFFS_PER_POLY - 1);

	logic [PW-1:0] pos_q;
	logic          s1_v_q, s2_v_q;
	logic [11:0]   x_s1;
	logic          d5_s1, last_s1;
	entry_t        entry_s2;

	logic              s1_ready, s2_ready, accept;
	logic signed [13:0] mapped;
	logic [11:0]       x_next;
	logic [16:0]       scaled;
	logic [25:0]       prod;
	logic [4:0]        code;

	assign s2_ready = !s2_v_q || !q_full;
	assign s1_ready = !s1_v_q || s2_ready;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;

	// clamp to the valid range, then map negative values up by q
	assign mapped = 14'(coefficient) + Q_MOD;
	always_comb begin
		if (coefficient < COEF_MIN) begin
			x_next = 12'd0;
		end else if (coefficient > COEF_MAX) begin
			x_next = 12'(COEF_MAX);
		end else if (coefficient < 13'sd0) begin
			x_next = 12'(mapped);
		end else begin
			x_next = 12'(coefficient);
		end
	end

	// round(x * 2^d / q) as ((x << d) + q/2) * 315 >> 20
	assign scaled = (d5_s1 ? {x_s1, 5'b0} : {1'b0, x_s1, 4'b0}) + HALF_Q;
	assign prod   = 26'(scaled) * MUL_CONST;
	assign code   = d5_s1 ? prod[MUL_SHIFT+4:MUL_SHIFT] : {1'b0, prod[MUL_SHIFT+3:MUL_SHIFT]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= (pos_q >= POS_LAST) ? '0 : pos_q + 1'b1;
			end
			if (s1_ready) begin
				s1_v_q <= accept;
			end
			if (s2_ready) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_next;
			d5_s1   <= d5;
			last_s1 <= (pos_q >= POS_LAST);
		end
		if (s2_ready && s1_v_q) begin
			entry_s2.code <= code;
			entry_s2.d5   <= d5_s1;
			entry_s2.last <= last_s1;
		end
	end

	assign q_push  = s2_v_q && !q_full;
	assign q_entry = entry_s2;

endmodule

`default_nettype wire

/* hdl/ccp_fifo.sv */
`default_nettype none

module ccp_fifo import ccp_pkg::*; #(
	parameter int WIDTH = 7,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* hdl/ccp_packer.sv */
`default_nettype none

module ccp_packer import ccp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire entry_t     q_entry,
	input  wire logic       q_empty,
	output logic            q_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic      [7:0] packed_byte,
	output logic            last_byte
);

	logic [11:0] buf_q;
	logic [3:0]  held_q;
	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic [11:0] merged;
	logic [3:0]  held_n;
	logic        produces, slot_free;

	assign merged    = buf_q | ({7'b0, q_entry.code} << held_q);
	assign held_n    = held_q + (q_entry.d5 ? 4'd5 : 4'd4);
	assign produces  = q_entry.last || (held_n >= BYTE_BITS);
	assign slot_free = !out_v_q || pop;
	// a coefficient that completes no byte never waits on the output
	assign q_pop     = !q_empty && (!produces || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			held_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_entry.last) begin
					buf_q  <= '0;
					held_q <= '0;
				end else if (produces) begin
					buf_q  <= {8'b0, merged[11:8]};
					held_q <= held_n - BYTE_BITS;
				end else begin
					buf_q  <= merged;
					held_q <= held_n;
				end
			end
			if (q_pop && produces) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && produces) begin
			out_byte_q <= merged[7:0];
			out_last_q <= q_entry.last;
		end
	end

	assign empty       = !out_v_q;
	assign packed_byte = out_byte_q;
	assign last_byte   = out_last_q;

`ifndef SYNTHESIS
	a_held_below_byte: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < BYTE_BITS)
		else $error("packer holds a full byte");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.last) |=> (out_v_q && out_last_q && held_q == 4'd0))
		else $error("end of polynomial not flushed");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!q_pop |=> ($stable(buf_q) && $stable(held_q)))
		else $error("packer state moved without a transfer");
`endif

endmodule

`default_nettype wire

/* hdl/coeff_compress_packer_unit.sv */
`default_nettype none

// Coefficient compressor and byte packer. Each transfer on push carries one
// signed coefficient; it is clamped, mapped into [0, q), compressed to 4 or 5
// bits (5 if the mode written by cfg_write is compressed_bits == 5, else 4,
// sampled when the coefficient is taken) and packed LSB first into bytes,
// read out through empty/pop. The last coefficient of every COEFFS_PER_POLY
// block always yields a byte with last_byte set, zero padded. The block
// sustains one coefficient per cycle unless the output stalls: the front end
// has two pipeline stages with a single constant multiply, and the packer
// retires one queue entry per cycle unless a finished byte waits on output.
// A byte passes both front-end stages, the queue and the packer's output
// register; a QUEUE_DEPTH-entry queue between them absorbs output stalls.
module coeff_compress_packer_unit import ccp_pkg::*; #(
	parameter int COEFFS_PER_POLY = COEFFS_PER_POLY_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic        [2:0]  compressed_bits,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [12:0] coefficient,
	output logic                    empty,
	input  wire logic               pop,
	output logic             [7:0]  packed_byte,
	output logic                    last_byte
);

	logic [2:0] mode_q;
	logic       q_push, q_full, q_pop, q_empty;
	entry_t     front_entry, queue_entry;
	logic [$bits(entry_t)-1:0] queue_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_write) begin
			mode_q <= compressed_bits;
		end
	end

	ccp_front #(
		.COEFFS_PER_POLY(COEFFS_PER_POLY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.coefficient(coefficient),
		.d5         (mode_q == MODE_D5),
		.q_push     (q_push),
		.q_entry    (front_entry),
		.q_full     (q_full)
	);

	ccp_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(front_entry),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(queue_rd_data),
		.empty  (q_empty)
	);

	assign queue_entry = entry_t'(queue_rd_data);

	ccp_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_entry    (queue_entry),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.packed_byte(packed_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
